// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the label checker.
// Stand-alone header; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lic_pkg.sv -----
// Package of the label identifier checker: widths, the reserved word table
// and character class helpers. No dependencies.
package lic_pkg;

   localparam int NUM_WORDS         = 28;
   localparam int NUM_POS           = 6;   // longest reserved word
   localparam int COUNT_W           = 6;
   localparam int COUNT_MAX         = 63;
   localparam int MAX_LABEL_LEN_DEF = 31;

   localparam logic [7:0] WORD_TEXT [NUM_WORDS][NUM_POS] = '{
      '{"m", "o", "v", 8'h00, 8'h00, 8'h00},
      '{"c", "m", "p", 8'h00, 8'h00, 8'h00},
      '{"a", "d", "d", 8'h00, 8'h00, 8'h00},
      '{"s", "u", "b", 8'h00, 8'h00, 8'h00},
      '{"l", "e", "a", 8'h00, 8'h00, 8'h00},
      '{"c", "l", "r", 8'h00, 8'h00, 8'h00},
      '{"n", "o", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "c", 8'h00, 8'h00, 8'h00},
      '{"d", "e", "c", 8'h00, 8'h00, 8'h00},
      '{"j", "m", "p", 8'h00, 8'h00, 8'h00},
      '{"b", "n", "e", 8'h00, 8'h00, 8'h00},
      '{"j", "s", "r", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "d", 8'h00, 8'h00, 8'h00},
      '{"p", "r", "n", 8'h00, 8'h00, 8'h00},
      '{"r", "t", "s", 8'h00, 8'h00, 8'h00},
      '{"s", "t", "o", "p", 8'h00, 8'h00},
      '{"d", "a", "t", "a", 8'h00, 8'h00},
      '{"s", "t", "r", "i", "n", "g"},
      '{"e", "n", "t", "r", "y", 8'h00},
      '{"e", "x", "t", "e", "r", "n"},
      '{"r", "0", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "1", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "2", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "3", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "4", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "5", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "6", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "7", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
      3'd4, 3'd6, 3'd5, 3'd6,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
   };

   // per-word step control handed to every cell
   typedef struct packed {
      logic advance;   // non-terminator word accepted
      logic clear;     // terminator accepted
   } step_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

// ----- rtl/core/lic_cell.sv -----
// One position cell of the reserved word matcher: holds the position token
// and matches the current byte against every word at its position. Uses lic_pkg.
module lic_cell #(
   parameter int POS = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lic_pkg::step_type             step,
   input  logic [7:0]                    char_i,
   input  logic                          token_i,
   output logic                          token_o,
   output logic [lic_pkg::NUM_WORDS-1:0] match_o
);

   localparam logic TOKEN_INIT = (POS == 0);

   logic token_ff;
   logic token_in;

   always_comb begin
      priority if (step.clear) begin
         token_in = TOKEN_INIT;
      end else if (step.advance) begin
         token_in = token_i;
      end else begin
         token_in = token_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= TOKEN_INIT;
      end else begin
         token_ff <= token_in;
      end
   end

   always_comb begin
      for (int w = 0; w < lic_pkg::NUM_WORDS; w++) begin
         match_o[w] = token_ff && (POS < int'(lic_pkg::WORD_LEN[w]))
                      && (lic_pkg::WORD_TEXT[w][POS] == char_i);
      end
   end

   assign token_o = token_ff;

endmodule

// ----- rtl/core/label_identifier_checker.sv -----
// Label identifier checker: takes a label one byte per word, ended by a zero
// byte, and returns one bit that says whether it is a legal identifier.
// Request channel: req_valid/req_ready/req_character, one byte per word.
// Response channel: rsp_valid/rsp_ready/rsp_valid_res, one word per label,
// sent only for the zero terminator; other bytes produce no response.
// Throughput: one byte per cycle, every cycle, while responses are taken.
// Response: the verdict is in the response register in the cycle after the
// terminator is accepted.
// A row of position cells passes a token along one step per byte; the cell
// holding the token matches the byte against all reserved words at once.
// Rules: 1 to MAX_LABEL_LEN bytes, first a letter, rest letters or digits,
// not one of the 28 reserved words (case-sensitive).
// Reset (synchronous, active high) empties the response register and
// returns the label state to an empty label.
// If a response is waiting and rsp_ready is low, req_ready drops; bytes
// keep flowing only when the response register is empty or being drained.
// Depends on lic_pkg, lic_cell and assert_macros.svh.
`include "assert_macros.svh"

module label_identifier_checker #(
   parameter int MAX_LABEL_LEN = lic_pkg::MAX_LABEL_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);

   localparam int NW = lic_pkg::NUM_WORDS;
   localparam int NP = lic_pkg::NUM_POS;
   localparam int CW = lic_pkg::COUNT_W;

   localparam logic [CW-1:0] COUNT_SAT = CW'(lic_pkg::COUNT_MAX);
   localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LABEL_LEN);

   logic [CW-1:0]  count_ff, count_in;
   logic           chars_ok_ff, chars_ok_in;
   logic [NW-1:0]  cand_ff, cand_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_res_ff, rsp_res_in;

   logic                   accept;
   logic                   term;
   lic_pkg::step_type      step;
   logic [NP-1:0]          tok;
   logic [NP-1:0]          tok_left;
   logic [NP-1:0][NW-1:0]  match;
   logic [NW-1:0]          match_any;
   logic [NW-1:0]          len_hit;
   logic                   reserved;
   logic                   char_legal;
   logic                   verdict;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign term         = (req_character == 8'h00);
   assign step.advance = accept && !term;
   assign step.clear   = accept && term;

   assign tok_left = {tok[NP-2:0], 1'b0};

   for (genvar k = 0; k < NP; k++) begin : g_cell
      lic_cell #(
         .POS (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .step    (step),
         .char_i  (req_character),
         .token_i (tok_left[k]),
         .token_o (tok[k]),
         .match_o (match[k])
      );
   end

   always_comb begin
      match_any = '0;
      for (int k = 0; k < NP; k++) begin
         match_any = match_any | match[k];
      end
      for (int w = 0; w < NW; w++) begin
         len_hit[w] = ({{(CW-3){1'b0}}, lic_pkg::WORD_LEN[w]} == count_ff);
      end
   end

   assign reserved   = |(cand_ff & len_hit);
   assign char_legal = lic_pkg::is_letter(req_character)
                       || ((count_ff != '0) && lic_pkg::is_digit(req_character));
   assign verdict    = (count_ff != '0) && (count_ff <= LEN_LIMIT)
                       && (count_ff != COUNT_SAT) && chars_ok_ff && !reserved;

   always_comb begin
      count_in     = count_ff;
      chars_ok_in  = chars_ok_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (step.clear) begin
         count_in     = '0;
         chars_ok_in  = 1'b1;
         cand_in      = '1;
         rsp_valid_in = 1'b1;
         rsp_res_in   = verdict;
      end else if (step.advance) begin
         count_in    = (count_ff == COUNT_SAT) ? count_ff : count_ff + 1'b1;
         chars_ok_in = chars_ok_ff && char_legal;
         cand_in     = cand_ff & match_any;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chars_ok_ff  <= 1'b1;
         cand_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chars_ok_ff  <= chars_ok_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   // at most one cell holds the position token
   `ASSERT_ALWAYS(a_token_onehot, clock, reset, $onehot0(tok))
   // a token exists exactly while the label is shorter than the longest word
   `ASSERT_ALWAYS(a_token_count, clock, reset, ((count_ff < CW'(NP)) == (|tok)))
   // a terminator leaves an empty label behind
   `ASSERT_IMPLY(a_term_clears, clock, reset, step.clear,
                 (count_ff == '0) && chars_ok_ff && (cand_ff == '1) && tok[0])

endmodule
